>>> rtl/enn_pkg.sv
// package for the expiring nearest-neighbor route table
// shared types, status codes and state encoding; no dependencies
package enn_pkg;

    localparam int ADDR_W  = 32;
    localparam int ROAD_W  = 16;
    localparam int GROUP_W = 32;
    localparam int TIME_W  = 32;
    localparam int EXP_W   = 16;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 16;

    typedef enum logic [STAT_W-1:0] {
        ST_REFRESHED = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_EXPIRED   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_SHIFT,
        S_DIST,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] node_addr;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [ROAD_W-1:0] road_id;
        logic [GROUP_W-1:0] group_id;
        logic [TIME_W-1:0] now_time;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic              found;
        logic [STAT_W-1:0] update_status;
    } res_t;

endpackage

>>> rtl/enn_if.sv
// valid/ready channel carrying one payload struct
// depends on nothing; payload type is a parameter
interface enn_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/enn_mem.sv
// entry memory: one write port, one registered read port
// depends on enn_pkg for field widths
module enn_mem
    import enn_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CW    = 16,
    parameter int AW    = 6
)(
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [AW-1:0]                             waddr,
    input  logic [ADDR_W+2*CW+ROAD_W+GROUP_W+TIME_W-1:0] wdata,
    input  logic [AW-1:0]                             raddr,
    output logic [ADDR_W+2*CW+ROAD_W+GROUP_W+TIME_W-1:0] rdata
);
    localparam int W = ADDR_W + 2*CW + ROAD_W + GROUP_W + TIME_W;
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/expiring_nearest_neighbor_route_table_core.sv
// top level of the expiring nearest-neighbor route table
// depends on enn_pkg, enn_if and enn_mem
//
//  channel   dir  payload
//  cmd       in   command, node_addr, pos_x, pos_y, road_id, group_id, now_time
//  res       out  result_addr, found, update_status
//  cfg       in   cfg_we / cfg_data (expire_time)
//
// one item at a time; a scan reads one entry a cycle from the single read port.
// when an expired entry is removed, every later entry moves down one place
// (read then write per entry). reset empties the table at once (count cleared);
// expire_time resets to 5. the result waits in an output register; the next item
// is accepted and scanned meanwhile and holds in its last state until it is free.
module expiring_nearest_neighbor_route_table_core
    import enn_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    enn_if.sink               cmd,
    enn_if.source             res,
    input  logic              cfg_we,
    input  logic [EXP_W-1:0]  cfg_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = COORD_BITS;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = 2*CW + 1;
    localparam int W  = ADDR_W + 2*CW + ROAD_W + GROUP_W + TIME_W;

    state_t state_reg, state_next;
    cmd_t   req_reg, req_next;
    res_t   out_reg, out_next;
    status_t stat_reg, stat_next;
    logic   out_valid_reg, out_valid_next;
    logic [EXP_W-1:0] exp_reg;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [DW-1:0] best_reg, best_next;
    logic [ADDR_W-1:0] baddr_reg, baddr_next;
    logic bfound_reg, bfound_next;
    logic [2*CW-1:0] sqx_reg, sqy_reg;
    logic cand_reg;
    logic [ADDR_W-1:0] caddr_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [W-1:0] wdata, rdata;

    logic [ADDR_W-1:0]  e_addr;
    logic [CW-1:0]      e_x, e_y;
    logic [ROAD_W-1:0]  e_road;
    logic [GROUP_W-1:0] e_group;
    logic [TIME_W-1:0]  e_stamp;
    logic [CW-1:0] dx, dy, mx, my;
    logic expired;
    logic [DW-1:0] dist_sum;

    assign {e_addr, e_x, e_y, e_road, e_group, e_stamp} = rdata;
    assign mx = CW'(req_reg.pos_x);
    assign my = CW'(req_reg.pos_y);
    assign dx = (mx >= e_x) ? mx - e_x : e_x - mx;
    assign dy = (my >= e_y) ? my - e_y : e_y - my;
    assign expired = (req_reg.now_time >= e_stamp) &&
                     ((req_reg.now_time - e_stamp) > TIME_W'(exp_reg));
    assign dist_sum = DW'(sqx_reg) + DW'(sqy_reg);

    enn_mem #(.DEPTH(TABLE_DEPTH), .CW(CW), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            exp_reg       <= EXP_W'(5);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_we)
            begin
                exp_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        out_reg    <= out_next;
        stat_reg   <= stat_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        baddr_reg  <= baddr_next;
        bfound_reg <= bfound_next;
        sqx_reg    <= dx * dx;
        sqy_reg    <= dy * dy;
        cand_reg   <= (state_reg == S_SCAN) && req_reg.command &&
                      (idx_reg != '0) && (idx_reg <= count_reg) &&
                      (e_group == req_reg.group_id) && (e_road != req_reg.road_id);
        caddr_reg  <= e_addr;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // idx counts issued reads; entry idx-1 is on rdata
                if (idx_reg != '0 && idx_reg <= count_reg && !req_reg.command)
                begin
                    if (expired)
                    begin
                        state_next = (NW'(idx_reg) < count_reg) ? S_WAIT : S_DONE;
                    end
                    else if (e_addr == req_reg.node_addr)
                    begin
                        state_next = S_DONE;
                    end
                end
                if (state_next == S_SCAN && idx_reg >= count_reg)
                begin
                    state_next = req_reg.command ? S_DIST : S_DONE;
                    if (idx_reg == '0 || idx_reg > count_reg)
                    begin
                        state_next = req_reg.command ? S_DIST : S_DONE;
                    end
                end
            end
            S_WAIT:  state_next = S_SHIFT;
            S_SHIFT: state_next = (idx_reg + 2'd2 < count_reg) ? S_WAIT : S_DONE;
            S_DIST:  state_next = S_DONE;
            // hold until the output register is free
            S_DONE:  state_next = (out_valid_reg && !res.ready) ? S_DONE : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next       = req_reg;
        out_next       = out_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        baddr_next     = baddr_reg;
        bfound_next    = bfound_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = {req_reg.node_addr, mx, my, req_reg.road_id,
                 req_reg.group_id, req_reg.now_time};
        raddr = idx_reg[AW-1:0];
        cmd.ready = 1'b0;

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        // a lookup candidate from two reads back, compared after the squares
        if (cand_reg && (!bfound_reg || dist_sum < best_reg))
        begin
            best_next   = dist_sum;
            baddr_next  = caddr_reg;
            bfound_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd.ready   = 1'b1;
                req_next    = cmd.payload;
                idx_next    = '0;
                bfound_next = 1'b0;
                raddr       = '0;
            end
            S_SCAN:
            begin
                idx_next  = idx_reg + 1'b1;
                raddr     = idx_reg[AW-1:0];
                stat_next = ST_INSERTED;
                if (state_next == S_WAIT)
                begin
                    // idx-1 expired; pull entry idx down
                    idx_next  = idx_reg - 1'b1;
                    raddr     = idx_reg[AW-1:0];
                    stat_next = ST_EXPIRED;
                end
                else if (state_next == S_DONE && !req_reg.command)
                begin
                    if (idx_reg != '0 && idx_reg <= count_reg && expired)
                    begin
                        stat_next  = ST_EXPIRED;
                        count_next = count_reg - 1'b1;
                    end
                    else if (idx_reg != '0 && idx_reg <= count_reg &&
                             e_addr == req_reg.node_addr)
                    begin
                        we        = 1'b1;
                        waddr     = AW'(idx_reg - 1'b1);
                        stat_next = ST_REFRESHED;
                    end
                    else if (count_reg >= NW'(TABLE_DEPTH))
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = count_reg[AW-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_WAIT:
            begin
                raddr = AW'(idx_reg + 1'b1);
            end
            S_SHIFT:
            begin
                we       = 1'b1;
                waddr    = idx_reg[AW-1:0];
                wdata    = rdata;
                idx_next = idx_reg + 1'b1;
                raddr    = AW'(idx_reg + 2'd2);
                if (state_next == S_DONE)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            S_DIST:
            begin
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    if (req_reg.command)
                    begin
                        out_next = '{result_addr: bfound_reg ? baddr_reg : '0,
                                     found: bfound_reg, update_status: ST_REFRESHED};
                    end
                    else
                    begin
                        out_next = '{result_addr: '0, found: 1'b0,
                                     update_status: stat_reg};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(TABLE_DEPTH)) else $error("entry count above depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> (state_reg == S_IDLE))
        else $error("transfer accepted while busy");
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid_reg) else $error("result not raised");
`endif
endmodule

>>> bench/route_cmd_pkg.sv
// command codes shared by the route table bench files
// depends on nothing
`timescale 1ns / 1ps
package route_cmd_pkg;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

endpackage

>>> bench/route_table_checker.sv
// checker for the expiring nearest-neighbor route table: mirrors the table,
// predicts each result and compares it; depends on enn_pkg and route_cmd_pkg
`timescale 1ns / 1ps
module route_table_checker
    import enn_pkg::*;
    import route_cmd_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  cmd_t             cmd_payload,
    input  logic             res_valid,
    input  logic             res_ready,
    input  res_t             res_payload,
    input  logic             cfg_we,
    input  logic [EXP_W-1:0] cfg_data,
    output int               errors,
    output int               outstanding,
    output int               lookups,
    output int               hits,
    output int               removals,
    output int               drops
);

    logic [EXP_W-1:0]   expiry;
    int                 fill;
    logic [ADDR_W-1:0]  tbl_addr  [TABLE_DEPTH];
    logic [POS_W-1:0]   tbl_x     [TABLE_DEPTH];
    logic [POS_W-1:0]   tbl_y     [TABLE_DEPTH];
    logic [ROAD_W-1:0]  tbl_road  [TABLE_DEPTH];
    logic [GROUP_W-1:0] tbl_group [TABLE_DEPTH];
    logic [TIME_W-1:0]  tbl_stamp [TABLE_DEPTH];
    res_t               expected_results [$];

    assign outstanding = expected_results.size();

    function automatic void store_entry(int i, cmd_t c);
        tbl_addr[i]  = c.node_addr;
        tbl_x[i]     = c.pos_x;
        tbl_y[i]     = c.pos_y;
        tbl_road[i]  = c.road_id;
        tbl_group[i] = c.group_id;
        tbl_stamp[i] = c.now_time;
    endfunction

    function automatic res_t predict_route(cmd_t c);
        res_t              r;
        bit                done;
        logic [TIME_W-1:0] age;
        logic [31:0]       dx;
        logic [31:0]       dy;
        logic [63:0]       d;
        logic [63:0]       best;
        int                i;
        int                k;
        r = '0;
        best = '0;
        done = 0;
        if (c.command == CMD_UPDATE)
        begin
            for (i = 0; i < fill && !done; i++)
            begin
                age = c.now_time - tbl_stamp[i];
                // stamps ahead of now never age out
                if (c.now_time >= tbl_stamp[i] && age > {16'd0, expiry})
                begin
                    for (k = i; k + 1 < fill; k++)
                    begin
                        tbl_addr[k]  = tbl_addr[k+1];
                        tbl_x[k]     = tbl_x[k+1];
                        tbl_y[k]     = tbl_y[k+1];
                        tbl_road[k]  = tbl_road[k+1];
                        tbl_group[k] = tbl_group[k+1];
                        tbl_stamp[k] = tbl_stamp[k+1];
                    end
                    fill--;
                    r.update_status = ST_EXPIRED;
                    done = 1;
                end
                else if (tbl_addr[i] == c.node_addr)
                begin
                    store_entry(i, c);
                    r.update_status = ST_REFRESHED;
                    done = 1;
                end
            end
            if (!done)
            begin
                if (fill >= TABLE_DEPTH)
                    r.update_status = ST_FULL;
                else
                begin
                    store_entry(fill, c);
                    fill++;
                    r.update_status = ST_INSERTED;
                end
            end
        end
        else
        begin
            for (i = 0; i < fill; i++)
            begin
                if (tbl_group[i] == c.group_id && tbl_road[i] != c.road_id)
                begin
                    dx = (c.pos_x >= tbl_x[i]) ? c.pos_x - tbl_x[i] : tbl_x[i] - c.pos_x;
                    dy = (c.pos_y >= tbl_y[i]) ? c.pos_y - tbl_y[i] : tbl_y[i] - c.pos_y;
                    d = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
                    // strict compare keeps the earliest entry on a tie
                    if (!r.found || d < best)
                    begin
                        best = d;
                        r.result_addr = tbl_addr[i];
                        r.found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            expiry = 16'd5;
            fill = 0;
            errors = 0;
            lookups = 0;
            hits = 0;
            removals = 0;
            drops = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                expiry = cfg_data;
            if (res_valid && res_ready)
            begin
                got = res_payload;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with nothing pending: addr %h found %0d status %0d",
                                 $time, got.result_addr, got.found, got.update_status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.result_addr !== want.result_addr || got.found !== want.found
                        || got.update_status !== want.update_status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: expected addr %h found %0d status %0d, got addr %h found %0d status %0d",
                                     $time, want.result_addr, want.found, want.update_status,
                                     got.result_addr, got.found, got.update_status);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                want = predict_route(cmd_payload);
                if (cmd_payload.command == CMD_LOOKUP)
                begin
                    lookups++;
                    if (want.found)
                        hits++;
                end
                else if (want.update_status == ST_EXPIRED)
                    removals++;
                else if (want.update_status == ST_FULL)
                    drops++;
                expected_results = {expected_results, want};
            end
        end
    end

endmodule

>>> bench/tb.sv
// top of the route table bench: clock, reset, stimulus, watchdog and verdict
// depends on enn_pkg, enn_if, route_cmd_pkg, route_table_checker and the core
`timescale 1ns / 1ps
module tb;
    import enn_pkg::*;
    import route_cmd_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 500;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [EXP_W-1:0] cfg_data;
    int               errors;
    int               outstanding;
    int               lookups;
    int               hits;
    int               removals;
    int               drops;
    int               idle_cycles;
    int               sent;
    bit               quiet_tx;
    bit               quiet_rx;
    bit               hold_rx;
    logic [TIME_W-1:0] clock_now;
    logic [ADDR_W-1:0] addr_pool [80];
    logic [GROUP_W-1:0] group_pool [4];

    enn_if #(.payload_t(cmd_t)) cmd_ch ();
    enn_if #(.payload_t(res_t)) res_ch ();

    expiring_nearest_neighbor_route_table_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .res      (res_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    route_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_ch.valid),
        .cmd_ready   (cmd_ch.ready),
        .cmd_payload (cmd_ch.payload),
        .res_valid   (res_ch.valid),
        .res_ready   (res_ch.ready),
        .res_payload (res_ch.payload),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .lookups     (lookups),
        .hits        (hits),
        .removals    (removals),
        .drops       (drops)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rx)
            begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            stall = quiet_rx ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    function automatic cmd_t make_cmd(logic op, logic [31:0] a, logic [15:0] x,
                                       logic [15:0] y, logic [15:0] road,
                                       logic [31:0] grp, logic [31:0] t);
        cmd_t c;
        c.command   = op;
        c.node_addr = a;
        c.pos_x     = x;
        c.pos_y     = y;
        c.road_id   = road;
        c.group_id  = grp;
        c.now_time  = t;
        return c;
    endfunction

    task automatic send_cmd(cmd_t c);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        sent++;
    endtask

    task automatic drain_and_write(logic [EXP_W-1:0] v);
        cmd_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (140) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly plausible traffic from a small neighbor set, some pure noise
    function automatic cmd_t random_cmd();
        logic [31:0] t;
        logic        op;
        if ($urandom_range(0, 9) == 0)
            return make_cmd(1'($urandom), $urandom, 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom, $urandom);
        clock_now = clock_now + $urandom_range(0, 2);
        t = ($urandom_range(0, 19) == 0) ? clock_now - $urandom_range(1, 10) : clock_now;
        op = ($urandom_range(0, 99) < 35) ? CMD_LOOKUP : CMD_UPDATE;
        return make_cmd(op, addr_pool[$urandom_range(0, 79)], 16'($urandom),
                        16'($urandom),
                        ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3)),
                        group_pool[$urandom_range(0, 3)], t);
    endfunction

    initial
    begin
        int i;
        int r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
        idle_cycles = 0;
        sent = 0;
        quiet_tx = 0;
        quiet_rx = 0;
        hold_rx = 0;
        clock_now = 32'd1000;
        for (i = 0; i < 80; i++)
            addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        group_pool[0] = 32'h0;
        group_pool[1] = 32'hFFFF_FFFF;
        group_pool[2] = 32'd7;
        group_pool[3] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty lookup, extremes, ties, address zero, future stamp, expiry
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd0, 16'd0, 16'd0, 32'h0, 32'd0));
        send_cmd(make_cmd(CMD_UPDATE, 32'h0, 16'h0, 16'h0, 16'd1, 32'h0, 32'd100));
        send_cmd(make_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd2, 32'h0,
                          32'd100));
        send_cmd(make_cmd(CMD_UPDATE, 32'd5, 16'd10, 16'd10, 16'd3, 32'h0, 32'd101));
        send_cmd(make_cmd(CMD_UPDATE, 32'd6, 16'd10, 16'd10, 16'd4, 32'h0, 32'd101));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd10, 16'd10, 16'd9, 32'h0, 32'd101));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd0, 16'd0, 16'd9, 32'h0, 32'd101));
        send_cmd(make_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd1, 32'h0, 32'd101));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'd101));
        send_cmd(make_cmd(CMD_UPDATE, 32'd5, 16'd20, 16'd30, 16'd3, 32'h0, 32'd102));
        send_cmd(make_cmd(CMD_UPDATE, 32'd7, 16'd1, 16'd1, 16'd5, 32'hFFFF_FFFF, 32'd50));
        send_cmd(make_cmd(CMD_UPDATE, 32'd8, 16'd1, 16'd1, 16'd6, 32'hFFFF_FFFF, 32'd107));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd107));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd0, 16'd0, 16'd0, 32'd3, 32'hFFFF_FFFF));

        // fill the table past its depth with nothing aging out
        drain_and_write(16'hFFFF);
        quiet_tx = 1;
        for (i = 0; i < 70; i++)
            send_cmd(make_cmd(CMD_UPDATE, 32'h1000 + i, 16'($urandom), 16'($urandom),
                              16'(i % 3), 32'd7, 32'd200));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd500, 16'd500, 16'd9, 32'd7, 32'd200));
        quiet_tx = 0;

        // zero expiry: each later update removes the head and shifts the table
        drain_and_write(16'd0);
        for (i = 0; i < 8; i++)
            send_cmd(make_cmd(CMD_UPDATE, 32'h2000 + i, 16'd3, 16'd4, 16'd1, 32'd7,
                              32'd300));
        send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 16'd0, 16'd0, 16'd9, 32'd7, 32'd300));

        // random rounds under several expiry settings
        for (r = 0; r < 4; r++)
        begin
            case (r)
                0: drain_and_write(16'd5);
                1: drain_and_write(16'($urandom_range(1, 50)));
                2: drain_and_write(16'hFFFF);
                default: drain_and_write(16'd0);
            endcase
            for (i = 0; i < RANDOM_ITEMS / 4; i++)
            begin
                if (i % 20 == 0)
                begin
                    quiet_tx = ($urandom_range(0, 3) == 0);
                    quiet_rx = ($urandom_range(0, 3) == 0);
                end
                if (r == 1 && i == 40)
                    hold_rx = 1;
                if (r == 2 && i == 60)
                begin
                    cmd_ch.valid <= 1'b0;
                    wait (outstanding == 0);
                end
                send_cmd(random_cmd());
            end
        end
        quiet_tx = 0;
        quiet_rx = 0;

        cmd_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (140) @(posedge clk);
        $display("sent %0d commands: %0d lookups (%0d hits), %0d expiry removals, %0d full drops",
                 sent, lookups, hits, removals, drops);
        $display("expiry settings covered: reset default, zero, maximum and a random value");
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/enn_pkg.sv
rtl/enn_if.sv
rtl/enn_mem.sv
rtl/expiring_nearest_neighbor_route_table_core.sv
bench/route_cmd_pkg.sv
bench/route_table_checker.sv
bench/tb.sv
